// ===== rtl/ssm_pkg.sv =====
package ssm_pkg;

  // Field widths of the sample and result channels
  localparam int unsigned SampleW   = 7;
  localparam int unsigned BinCntW   = 16;
  localparam int unsigned FracW     = 8;
  localparam int unsigned MeanW     = 15;
  localparam int unsigned VarW      = 20;
  localparam int unsigned CountOutW = 16;

  // Saturation limits
  localparam logic [BinCntW-1:0] BinCntMax = '1;
  localparam logic [MeanW-1:0]   MeanMax   = '1;
  localparam logic [VarW-1:0]    VarMax    = '1;

  // Set sequencer: run, drain the histogram stage, then the end-of-set math
  typedef enum logic [3:0] {
    ST_RUN,
    ST_DRAIN,
    ST_SNAP,
    ST_MUL1,
    ST_MUL2,
    ST_ACC,
    ST_SUB,
    ST_DIVM,
    ST_DIVV,
    ST_EMIT
  } ssm_state_e;

endpackage

// ===== rtl/ssm_ram.sv =====
module ssm_ram #(
  parameter int Width = 16,
  parameter int Depth = 128,
  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ssm_div.sv =====
module ssm_div #(
  parameter int DW = 54,
  parameter int VW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o
);

  localparam int CW = (DW > 1) ? $clog2(DW) : 1;

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] step_q, step_d;
  logic [DW-1:0] quo_q;
  logic [VW-1:0] rem_q;
  logic [VW-1:0] dvs_q;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          fits;
  logic [VW-1:0] rem_next;

  // Restoring step: shift in one dividend bit, subtract if it fits
  always_comb begin
    trial    = {rem_q, quo_q[DW-1]};
    fits     = (trial >= {1'b0, dvs_q});
    diff     = trial - {1'b0, dvs_q};
    rem_next = fits ? diff[VW-1:0] : trial[VW-1:0];
  end

  // Step counter and completion pulse
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
    end else if (busy_q) begin
      step_d = step_q + CW'(1);
      if (step_q == CW'(DW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // Dividend shifts out as quotient bits shift in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DW-2:0], fits};
      rem_q <= rem_next;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== rtl/stream_statistics_mode.sv =====
// Streaming set statistics: mean, population variance, mode, max, min, count.
// Input channel: in_valid_i / in_stall_o with sample_value_i and last_sample_i.
// Each sample is one transfer; last_sample_i closes the set. Output channel:
// out_valid_o / out_stall_i carries one result per set.
// Samples that do not close a set are taken one per cycle. The histogram lives
// in a RAM with a registered read; a read-modify-write per sample
// with forwarding lets the same bin be hit on consecutive cycles.
// After the closing sample, in_stall_o stays high while a shared radix-2
// divider runs the mean and then the variance division, DivW bits each
// (DivW = 2*CntW+22, 54 at the default count limit), and until the result
// is loaded into the output register.
// A finished result sits in an output register; a new set may start while it
// waits. If the receiver still stalls the previous result when the next one is
// ready, the block holds the new result (and the input) until it is taken.
// Samples past the count limit are dropped and flagged in count_overflow_o.
// Reset empties the set and the output register; no clearing pass is needed.
module stream_statistics_mode
  import ssm_pkg::*;
#(
  parameter int NUM_BINS  = 128,
  parameter int MAX_COUNT = 65535
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [SampleW-1:0]   sample_value_i,
  input  logic                 last_sample_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [MeanW-1:0]     mean_fixed_o,
  output logic [VarW-1:0]      variance_fixed_o,
  output logic [SampleW-1:0]   mode_value_o,
  output logic [SampleW-1:0]   max_value_o,
  output logic [SampleW-1:0]   min_value_o,
  output logic [CountOutW-1:0] set_count_o,
  output logic                 count_overflow_o
);

  localparam int BinAw = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int CntW  = $clog2(MAX_COUNT + 1);
  localparam int SumW  = CntW + SampleW;
  localparam int SqW   = CntW + 2 * SampleW;
  localparam int SqLoW = SqW / 2;
  localparam int SqHiW = SqW - SqLoW;
  localparam int PloW  = CntW + SqLoW;
  localparam int PhiW  = CntW + SqHiW;
  localparam int NumW  = CntW + SqW;
  localparam int NnW   = 2 * CntW;
  localparam int DivW  = NumW + FracW;

  ssm_state_e state_q, state_d;

  // Running set state
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [SumW-1:0]     sum_q, sum_d;
  logic [SqW-1:0]      sq_q, sq_d;
  logic [SampleW-1:0]  max_q, max_d;
  logic [SampleW-1:0]  min_q, min_d;
  logic [BinCntW-1:0]  best_q, best_d;
  logic [SampleW-1:0]  mode_q, mode_d;
  logic                ovf_q, ovf_d;
  logic [NUM_BINS-1:0] bin_vld_q, bin_vld_d;

  // Histogram update stage
  logic                s1_valid_q, s1_valid_d;
  logic [SampleW-1:0]  s1_val_q, s1_val_d;
  logic                s1_fwd_q, s1_fwd_d;
  logic [BinCntW-1:0]  s1_fwd_cnt_q, s1_fwd_cnt_d;
  logic [BinAw-1:0]    s1_addr;
  logic [BinCntW-1:0]  bin_rdata;
  logic [BinCntW-1:0]  bin_old;
  logic [BinCntW-1:0]  bin_new;

  // Input side
  logic                  in_xfer;
  logic                  in_bin;
  logic                  take;
  logic [BinAw-1:0]      in_addr;
  logic [2*SampleW-1:0]  sample_sq;

  // End-of-set datapath
  logic [CntW-1:0]     snap_cnt_q;
  logic [SumW-1:0]     snap_sum_q;
  logic [SqW-1:0]      snap_sq_q;
  logic [SampleW-1:0]  snap_mode_q;
  logic [SampleW-1:0]  snap_max_q;
  logic [SampleW-1:0]  snap_min_q;
  logic                snap_ovf_q;
  logic [PloW-1:0]     prod_lo_q;
  logic [PhiW-1:0]     prod_hi_q;
  logic [NumW-1:0]     sum2_q;
  logic [NnW-1:0]      nn_q;
  logic [NumW-1:0]     nsq_q;
  logic [NumW-1:0]     num_q;
  logic [MeanW-1:0]    mean_q;
  logic [VarW-1:0]     var_q;

  // Divider hookup
  logic                div_start;
  logic [DivW-1:0]     div_dividend;
  logic [NnW-1:0]      div_divisor;
  logic                div_done;
  logic [DivW-1:0]     div_quot;
  logic [MeanW-1:0]    mean_sat;
  logic [VarW-1:0]     var_sat;

  // Output register
  logic                out_valid_q, out_valid_d;
  logic                out_load;
  logic [MeanW-1:0]    out_mean_q;
  logic [VarW-1:0]     out_var_q;
  logic [SampleW-1:0]  out_mode_q;
  logic [SampleW-1:0]  out_max_q;
  logic [SampleW-1:0]  out_min_q;
  logic [CntW-1:0]     out_cnt_q;
  logic                out_ovf_q;

  assign in_stall_o = (state_q != ST_RUN);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign in_bin     = (32'(sample_value_i) < NUM_BINS);
  assign in_addr    = BinAw'(sample_value_i);
  assign take       = (cnt_q < CntW'(MAX_COUNT));
  assign sample_sq  = (2*SampleW)'(sample_value_i) * (2*SampleW)'(sample_value_i);

  // Histogram memory: read at transfer, write back in the next cycle
  ssm_ram #(
    .Width (BinCntW),
    .Depth (NUM_BINS)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_addr),
    .wdata_i (bin_new),
    .re_i    (in_xfer && take && in_bin),
    .raddr_i (in_addr),
    .rdata_o (bin_rdata)
  );

  // Forward the previous write on a back-to-back hit, else a stale bin is zero
  always_comb begin
    s1_addr = BinAw'(s1_val_q);
    if (s1_fwd_q) begin
      bin_old = s1_fwd_cnt_q;
    end else if (bin_vld_q[s1_addr]) begin
      bin_old = bin_rdata;
    end else begin
      bin_old = '0;
    end
    bin_new = (bin_old == BinCntMax) ? bin_old : bin_old + BinCntW'(1);
  end

  // Set accumulation, histogram stage and end-of-set clear
  always_comb begin
    cnt_d        = cnt_q;
    sum_d        = sum_q;
    sq_d         = sq_q;
    max_d        = max_q;
    min_d        = min_q;
    best_d       = best_q;
    mode_d       = mode_q;
    ovf_d        = ovf_q;
    bin_vld_d    = bin_vld_q;
    s1_valid_d   = 1'b0;
    s1_val_d     = s1_val_q;
    s1_fwd_d     = 1'b0;
    s1_fwd_cnt_d = bin_new;

    if (s1_valid_q) begin
      bin_vld_d[s1_addr] = 1'b1;
      if (bin_new > best_q) begin
        best_d = bin_new;
        mode_d = s1_val_q;
      end
    end

    if (in_xfer) begin
      if (take) begin
        if (cnt_q == '0) begin
          max_d = sample_value_i;
          min_d = sample_value_i;
        end else begin
          if (sample_value_i > max_q) max_d = sample_value_i;
          if (sample_value_i < min_q) min_d = sample_value_i;
        end
        cnt_d = cnt_q + CntW'(1);
        sum_d = sum_q + SumW'(sample_value_i);
        sq_d  = sq_q + SqW'(sample_sq);
        if (in_bin) begin
          s1_valid_d = 1'b1;
          s1_val_d   = sample_value_i;
          s1_fwd_d   = s1_valid_q && (s1_addr == in_addr);
        end
      end else begin
        ovf_d = 1'b1;
      end
    end

    if (state_q == ST_SNAP) begin
      cnt_d     = '0;
      sum_d     = '0;
      sq_d      = '0;
      max_d     = '0;
      min_d     = '0;
      best_d    = '0;
      mode_d    = '0;
      ovf_d     = 1'b0;
      bin_vld_d = '0;
    end
  end

  // Sequencer
  always_comb begin
    state_d      = state_q;
    div_start    = 1'b0;
    div_dividend = DivW'({snap_sum_q, {FracW{1'b0}}});
    div_divisor  = NnW'(snap_cnt_q);
    unique case (state_q)
      ST_RUN: begin
        if (in_xfer && last_sample_i) state_d = ST_DRAIN;
      end
      ST_DRAIN: state_d = ST_SNAP;
      ST_SNAP:  state_d = ST_MUL1;
      ST_MUL1: begin
        div_start = 1'b1;
        state_d   = ST_MUL2;
      end
      ST_MUL2: state_d = ST_ACC;
      ST_ACC:  state_d = ST_SUB;
      ST_SUB:  state_d = ST_DIVM;
      ST_DIVM: begin
        div_dividend = {num_q, {FracW{1'b0}}};
        div_divisor  = nn_q;
        if (div_done) begin
          div_start = 1'b1;
          state_d   = ST_DIVV;
        end
      end
      ST_DIVV: begin
        if (div_done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load) state_d = ST_RUN;
      end
      default: state_d = ST_RUN;
    endcase
  end

  ssm_div #(
    .DW (DivW),
    .VW (NnW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Saturate quotients to the result widths
  assign mean_sat = (div_quot > DivW'(MeanMax)) ? MeanMax : MeanW'(div_quot);
  assign var_sat  = (div_quot > DivW'(VarMax)) ? VarMax : VarW'(div_quot);

  // Load the output register when it is empty or being drained
  assign out_load    = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      cnt_q       <= '0;
      sum_q       <= '0;
      sq_q        <= '0;
      max_q       <= '0;
      min_q       <= '0;
      best_q      <= '0;
      mode_q      <= '0;
      ovf_q       <= 1'b0;
      bin_vld_q   <= '0;
      s1_valid_q  <= 1'b0;
      s1_fwd_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      sq_q        <= sq_d;
      max_q       <= max_d;
      min_q       <= min_d;
      best_q      <= best_d;
      mode_q      <= mode_d;
      ovf_q       <= ovf_d;
      bin_vld_q   <= bin_vld_d;
      s1_valid_q  <= s1_valid_d;
      s1_fwd_q    <= s1_fwd_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    s1_val_q     <= s1_val_d;
    s1_fwd_cnt_q <= s1_fwd_cnt_d;

    if (state_q == ST_SNAP) begin
      snap_cnt_q  <= cnt_q;
      snap_sum_q  <= sum_q;
      snap_sq_q   <= sq_q;
      snap_mode_q <= mode_q;
      snap_max_q  <= max_q;
      snap_min_q  <= min_q;
      snap_ovf_q  <= ovf_q;
    end

    // n*sumsq in two halves, sum^2 and n^2 alongside
    if (state_q == ST_MUL1) begin
      prod_lo_q <= PloW'(snap_cnt_q) * PloW'(snap_sq_q[SqLoW-1:0]);
      sum2_q    <= NumW'(snap_sum_q) * NumW'(snap_sum_q);
      nn_q      <= NnW'(snap_cnt_q) * NnW'(snap_cnt_q);
    end
    if (state_q == ST_MUL2) begin
      prod_hi_q <= PhiW'(snap_cnt_q) * PhiW'(snap_sq_q[SqW-1:SqLoW]);
    end
    if (state_q == ST_ACC) begin
      nsq_q <= NumW'(prod_lo_q) + (NumW'(prod_hi_q) << SqLoW);
    end
    if (state_q == ST_SUB) begin
      num_q <= (nsq_q >= sum2_q) ? nsq_q - sum2_q : '0;
    end

    if (state_q == ST_DIVM && div_done) begin
      mean_q <= mean_sat;
    end

    // Hold the variance until the output register is free
    if (state_q == ST_DIVV && div_done) begin
      var_q <= var_sat;
    end

    if (out_load) begin
      out_mean_q <= mean_q;
      out_var_q  <= var_q;
      out_mode_q <= snap_mode_q;
      out_max_q  <= snap_max_q;
      out_min_q  <= snap_min_q;
      out_cnt_q  <= snap_cnt_q;
      out_ovf_q  <= snap_ovf_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign mean_fixed_o     = out_mean_q;
  assign variance_fixed_o = out_var_q;
  assign mode_value_o     = out_mode_q;
  assign max_value_o      = out_max_q;
  assign min_value_o      = out_min_q;
  assign set_count_o      = CountOutW'(out_cnt_q);
  assign count_overflow_o = out_ovf_q;

  // The best bin count never runs ahead of the samples taken
  a_best_le_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(best_q) <= 32'(cnt_q))
    else $error("best bin count exceeds sample count");

  // Once a set holds a sample, min and max stay ordered
  a_min_le_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> (min_q <= max_q))
    else $error("running minimum above running maximum");

  // The histogram stage is empty when the set is snapshotted and cleared
  a_drained_at_snap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SNAP) |-> !s1_valid_q)
    else $error("histogram update pending at set snapshot");

  // A result only appears after the emit step
  a_out_from_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_EMIT))
    else $error("result raised outside emit step");

endmodule
